// File: rtl/adcoc_pkg.sv
`timescale 1ns / 1ps

package adcoc_pkg;

    localparam int AVG_LOG2         = 10;
    localparam int ADC_BITS         = 12;
    localparam int FACTOR_FRAC_BITS = 16;

    localparam int CNT_W   = AVG_LOG2 + 1;
    localparam int SUM_W   = ADC_BITS + AVG_LOG2;
    localparam int DIFF_W  = ADC_BITS + 1;
    localparam int NSUM_W  = DIFF_W + 1;
    localparam int CUR_W   = ADC_BITS + FACTOR_FRAC_BITS + 1;
    localparam int WCUR_W  = CUR_W + 1;
    localparam int BUS_W   = ADC_BITS + FACTOR_FRAC_BITS;
    localparam int DELTA_W = BUS_W + 1;

    localparam logic [CNT_W-1:0] AVG_COUNT = CNT_W'(1) << AVG_LOG2;

    typedef logic        [ADC_BITS-1:0]         adc_code_t;
    typedef logic        [FACTOR_FRAC_BITS-1:0] factor_t;
    typedef logic signed [CUR_W-1:0]            current_t;
    typedef logic signed [WCUR_W-1:0]           w_current_t;
    typedef logic        [BUS_W-1:0]            bus_t;
    typedef logic signed [DELTA_W-1:0]          delta_t;
    typedef logic        [1:0]                  reg_idx_t;

    localparam logic ACT_CALIB   = 1'b0;
    localparam logic ACT_CONVERT = 1'b1;

    localparam reg_idx_t REG_CURRENT_FACTOR = 2'd0;
    localparam reg_idx_t REG_BUS_FACTOR     = 2'd1;
    localparam reg_idx_t REG_CURRENT_DIR    = 2'd2;

endpackage

// File: rtl/adc_offset_calib_and_phase_scaling.sv
`timescale 1ns / 1ps

// ADC offset calibration and phase/bus scaling.
// Input channel (s_*): one beat carries an action bit and the U, V and bus
// ADC codes. Calibrate beats are summed; after 1024 of them the next
// calibrate beat averages the sums into the U/V offsets and the calibrated
// bus value and sets calib_done. Convert beats subtract the offsets, apply
// the sense direction and current factor, form W = -(U+V), and report the
// scaled bus voltage and its delta to the calibrated value.
// Result channel (m_*): exactly one beat per input beat, in order. The
// current/bus fields of a calibrate result are zero.
// Config port: cfg_wr_en/cfg_addr/cfg_wdata, to be written by the user only
// while idle; the block does not enforce this. The input stage updates the
// calibration state and forms the corrected codes, the result stage holds
// the multiplier outputs. Each stage advances, one beat per cycle, when the
// one after it is empty or being drained, so a stalled receiver backs up
// two beats before s_ready drops. Reset clears the factors, direction,
// offsets, sums, sample count and done flag and empties both stages.
module adc_offset_calib_and_phase_scaling (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_wr_en,
    input  adcoc_pkg::reg_idx_t            cfg_addr,
    input  adcoc_pkg::factor_t             cfg_wdata,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic                           s_action,
    input  adcoc_pkg::adc_code_t           s_u_raw,
    input  adcoc_pkg::adc_code_t           s_v_raw,
    input  adcoc_pkg::adc_code_t           s_bus_raw,
    output logic                           m_valid,
    input  logic                           m_ready,
    output adcoc_pkg::current_t            m_u_current,
    output adcoc_pkg::current_t            m_v_current,
    output adcoc_pkg::w_current_t          m_w_current,
    output adcoc_pkg::bus_t                m_bus_volts,
    output adcoc_pkg::delta_t              m_bus_delta,
    output logic                           m_calib_done
);
    import adcoc_pkg::*;

    factor_t cur_factor_reg;
    factor_t bus_factor_reg;
    logic    cur_dir_reg;

    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [SUM_W-1:0] u_sum_reg, u_sum_next;
    logic [SUM_W-1:0] v_sum_reg, v_sum_next;
    logic [SUM_W-1:0] bus_sum_reg, bus_sum_next;
    adc_code_t        u_off_reg, u_off_next;
    adc_code_t        v_off_reg, v_off_next;
    bus_t             bus_cal_reg, bus_cal_next;
    logic             done_reg, done_next;

    logic s_fire;
    logic calib_fire;
    logic avg_fire;
    logic b_ready;

    logic [SUM_W-1:0] u_base, v_base, bus_base;
    adc_code_t        bus_avg;

    logic signed [DIFF_W-1:0] du, dv;
    logic signed [NSUM_W-1:0] dw;

    // input stage
    logic                     a_valid_reg;
    logic signed [DIFF_W-1:0] a_du_reg, a_du_next;
    logic signed [DIFF_W-1:0] a_dv_reg, a_dv_next;
    logic signed [NSUM_W-1:0] a_dw_reg, a_dw_next;
    adc_code_t                a_bus_reg, a_bus_next;
    bus_t                     a_cal_reg, a_cal_next;
    logic                     a_done_reg;

    // result stage
    logic       b_valid_reg;
    current_t   b_u_reg;
    current_t   b_v_reg;
    w_current_t b_w_reg;
    bus_t       b_bus_reg;
    delta_t     b_delta_reg;
    logic       b_done_reg;

    current_t                                  u_prod, v_prod;
    w_current_t                                w_prod;
    logic signed [FACTOR_FRAC_BITS:0]          cf_s;
    bus_t                                      bus_prod;

    assign b_ready    = !b_valid_reg || m_ready;
    assign s_ready    = !a_valid_reg || b_ready;
    assign s_fire     = s_valid && s_ready;
    assign calib_fire = s_fire && (s_action == ACT_CALIB);
    assign avg_fire   = calib_fire && (cnt_reg >= AVG_COUNT);

    // config
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_factor_reg <= '0;
            bus_factor_reg <= '0;
            cur_dir_reg    <= 1'b0;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                REG_CURRENT_FACTOR: cur_factor_reg <= cfg_wdata;
                REG_BUS_FACTOR:     bus_factor_reg <= cfg_wdata;
                REG_CURRENT_DIR:    cur_dir_reg    <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    // calibration state
    assign u_base   = (cnt_reg == '0) ? '0 : u_sum_reg;
    assign v_base   = (cnt_reg == '0) ? '0 : v_sum_reg;
    assign bus_base = (cnt_reg == '0) ? '0 : bus_sum_reg;
    assign bus_avg  = bus_sum_reg[SUM_W-1:AVG_LOG2];

    always_comb begin
        cnt_next     = cnt_reg;
        u_sum_next   = u_sum_reg;
        v_sum_next   = v_sum_reg;
        bus_sum_next = bus_sum_reg;
        u_off_next   = u_off_reg;
        v_off_next   = v_off_reg;
        bus_cal_next = bus_cal_reg;
        done_next    = done_reg;
        if (calib_fire) begin
            if (cnt_reg == '0) begin
                done_next = 1'b0;
            end
            if (cnt_reg < AVG_COUNT) begin
                u_sum_next   = u_base + SUM_W'(s_u_raw);
                v_sum_next   = v_base + SUM_W'(s_v_raw);
                bus_sum_next = bus_base + SUM_W'(s_bus_raw);
                cnt_next     = cnt_reg + CNT_W'(1);
            end else begin
                u_off_next   = u_sum_reg[SUM_W-1:AVG_LOG2];
                v_off_next   = v_sum_reg[SUM_W-1:AVG_LOG2];
                bus_cal_next = BUS_W'(bus_avg * bus_factor_reg);
                cnt_next     = '0;
                done_next    = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg     <= '0;
            u_sum_reg   <= '0;
            v_sum_reg   <= '0;
            bus_sum_reg <= '0;
            u_off_reg   <= '0;
            v_off_reg   <= '0;
            bus_cal_reg <= '0;
            done_reg    <= 1'b0;
        end else begin
            cnt_reg     <= cnt_next;
            u_sum_reg   <= u_sum_next;
            v_sum_reg   <= v_sum_next;
            bus_sum_reg <= bus_sum_next;
            u_off_reg   <= u_off_next;
            v_off_reg   <= v_off_next;
            bus_cal_reg <= bus_cal_next;
            done_reg    <= done_next;
        end
    end

    // offset-corrected codes, direction folded in
    always_comb begin
        du = $signed({1'b0, s_u_raw}) - $signed({1'b0, u_off_reg});
        dv = $signed({1'b0, s_v_raw}) - $signed({1'b0, v_off_reg});
        if (cur_dir_reg) begin
            du = -du;
            dv = -dv;
        end
        dw = -(NSUM_W'(du) + NSUM_W'(dv));
    end

    always_comb begin
        if (s_action == ACT_CONVERT) begin
            a_du_next  = du;
            a_dv_next  = dv;
            a_dw_next  = dw;
            a_bus_next = s_bus_raw;
            a_cal_next = bus_cal_reg;
        end else begin
            a_du_next  = '0;
            a_dv_next  = '0;
            a_dw_next  = '0;
            a_bus_next = '0;
            a_cal_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
        end else if (s_ready) begin
            a_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            a_du_reg   <= a_du_next;
            a_dv_reg   <= a_dv_next;
            a_dw_reg   <= a_dw_next;
            a_bus_reg  <= a_bus_next;
            a_cal_reg  <= a_cal_next;
            a_done_reg <= done_next;
        end
    end

    // scaling; full-scale products fit the result widths exactly
    assign cf_s     = $signed({1'b0, cur_factor_reg});
    assign u_prod   = a_du_reg * cf_s;
    assign v_prod   = a_dv_reg * cf_s;
    assign w_prod   = a_dw_reg * cf_s;
    assign bus_prod = BUS_W'(a_bus_reg * bus_factor_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_valid_reg <= 1'b0;
        end else if (b_ready) begin
            b_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (b_ready && a_valid_reg) begin
            b_u_reg     <= u_prod;
            b_v_reg     <= v_prod;
            b_w_reg     <= w_prod;
            b_bus_reg   <= bus_prod;
            b_delta_reg <= $signed({1'b0, bus_prod}) - $signed({1'b0, a_cal_reg});
            b_done_reg  <= a_done_reg;
        end
    end

    assign m_valid      = b_valid_reg;
    assign m_u_current  = b_u_reg;
    assign m_v_current  = b_v_reg;
    assign m_w_current  = b_w_reg;
    assign m_bus_volts  = b_bus_reg;
    assign m_bus_delta  = b_delta_reg;
    assign m_calib_done = b_done_reg;

    // checks
    a_cnt_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= AVG_COUNT)
        else $error("sample count past average length");

    a_done_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (cnt_reg != '0) |-> !done_reg)
        else $error("done flag set while accumulating");

    a_off_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !avg_fire |=> ($stable(u_off_reg) && $stable(v_off_reg) && $stable(bus_cal_reg)))
        else $error("offsets changed outside averaging beat");

    a_w_sum: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_w_current == -(WCUR_W'(m_u_current) + WCUR_W'(m_v_current))))
        else $error("W current is not the negated U+V sum");

    a_stage_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (a_valid_reg && !b_ready) |=> a_valid_reg)
        else $error("input stage dropped a beat under stall");

endmodule

// File: bench/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import adcoc_pkg::*;

    typedef struct packed {
        logic      action;
        adc_code_t u_code;
        adc_code_t v_code;
        adc_code_t bus_code;
    } sample_t;

    typedef struct packed {
        current_t   u_cur;
        current_t   v_cur;
        w_current_t w_cur;
        bus_t       bus_v;
        delta_t     delta;
        logic       done;
    } scaled_t;

    logic      aclk;
    logic      aresetn = 1'b0;
    logic      cfg_wr_en = 1'b0;
    reg_idx_t  cfg_addr = REG_CURRENT_FACTOR;
    factor_t   cfg_wdata = '0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    logic      s_action = ACT_CALIB;
    adc_code_t s_u_raw = '0;
    adc_code_t s_v_raw = '0;
    adc_code_t s_bus_raw = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    current_t   m_u_current;
    current_t   m_v_current;
    w_current_t m_w_current;
    bus_t       m_bus_volts;
    delta_t     m_bus_delta;
    logic       m_calib_done;

    adc_offset_calib_and_phase_scaling DUT (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_addr     (cfg_addr),
        .cfg_wdata    (cfg_wdata),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_action     (s_action),
        .s_u_raw      (s_u_raw),
        .s_v_raw      (s_v_raw),
        .s_bus_raw    (s_bus_raw),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_u_current  (m_u_current),
        .m_v_current  (m_v_current),
        .m_w_current  (m_w_current),
        .m_bus_volts  (m_bus_volts),
        .m_bus_delta  (m_bus_delta),
        .m_calib_done (m_calib_done)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    initial begin
        #2_000_000;
        $display("adc_offset_calib_and_phase_scaling test failed");
        $finish;
    end

    // predictor state and register mirror
    factor_t          cur_factor_m = '0;
    factor_t          bus_factor_m = '0;
    logic             dir_m = 1'b0;
    logic [CNT_W-1:0] cal_count = '0;
    logic [SUM_W-1:0] u_acc = '0;
    logic [SUM_W-1:0] v_acc = '0;
    logic [SUM_W-1:0] bus_acc = '0;
    adc_code_t        u_offset_m = '0;
    adc_code_t        v_offset_m = '0;
    bus_t             bus_cal_m = '0;
    logic             calib_flag = 1'b0;

    sample_t pending_samples[$];
    scaled_t expected_results[$];
    int      errors = 0;
    int      results_seen = 0;
    int      gen_cal_count = 0;

    function automatic scaled_t predict_sample(sample_t smp);
        scaled_t r;
        longint  iu, iv, vb;
        r = '0;
        if (smp.action == ACT_CALIB) begin
            if (cal_count == 0) begin
                u_acc = '0;
                v_acc = '0;
                bus_acc = '0;
                calib_flag = 1'b0;
            end
            if (cal_count < AVG_COUNT) begin
                u_acc += smp.u_code;
                v_acc += smp.v_code;
                bus_acc += smp.bus_code;
                cal_count++;
            end else begin
                u_offset_m = adc_code_t'(u_acc >> AVG_LOG2);
                v_offset_m = adc_code_t'(v_acc >> AVG_LOG2);
                bus_cal_m = bus_t'(longint'(adc_code_t'(bus_acc >> AVG_LOG2))
                                   * longint'(bus_factor_m));
                cal_count = '0;
                calib_flag = 1'b1;
            end
        end else begin
            iu = (longint'(smp.u_code) - longint'(u_offset_m)) * longint'(cur_factor_m);
            iv = (longint'(smp.v_code) - longint'(v_offset_m)) * longint'(cur_factor_m);
            if (dir_m) begin
                iu = -iu;
                iv = -iv;
            end
            vb = longint'(smp.bus_code) * longint'(bus_factor_m);
            r.u_cur = current_t'(iu);
            r.v_cur = current_t'(iv);
            r.w_cur = w_current_t'(-(iu + iv));
            r.bus_v = bus_t'(vb);
            r.delta = delta_t'(vb - longint'(bus_cal_m));
        end
        r.done = calib_flag;
        return r;
    endfunction

    task automatic note_error(string msg);
        errors++;
        if (errors <= 40)
            $display("ERROR @%0t beat %0d: %s", $time, results_seen, msg);
    endtask

    task automatic check_field(string name, longint got, longint want);
        if (got != want)
            note_error($sformatf("%s got %0d expected %0d", name, got, want));
    endtask

    // sender: bursts of random length separated by random gaps
    sample_t on_bus;
    int      burst_left = 1;
    int      gap_left = 0;

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready)
                expected_results.push_back(predict_sample(on_bus));
            if (!s_valid || s_ready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    s_valid <= 1'b0;
                end else if (pending_samples.size() > 0) begin
                    on_bus = pending_samples.pop_front();
                    s_valid   <= 1'b1;
                    s_action  <= on_bus.action;
                    s_u_raw   <= on_bus.u_code;
                    s_v_raw   <= on_bus.v_code;
                    s_bus_raw <= on_bus.bus_code;
                    burst_left--;
                    if (burst_left <= 0) begin
                        burst_left = $urandom_range(1, 40);
                        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                    end
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // receiver stall pattern, plus one long hold-off to back the block up
    int rx_mode = 0;
    int rx_mode_left = 0;
    int hold_left = 0;
    logic hold_done = 1'b0;

    always @(posedge aclk) begin
        if (hold_left > 0) begin
            hold_left <= hold_left - 1;
        end else if (!hold_done && results_seen >= 400) begin
            hold_left <= 250;
            hold_done <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        if (hold_left > 0) begin
            m_ready <= 1'b0;
        end else begin
            if (rx_mode_left == 0) begin
                rx_mode = $urandom_range(0, 3);
                rx_mode_left = $urandom_range(30, 300);
            end else begin
                rx_mode_left--;
            end
            case (rx_mode)
                0: m_ready <= 1'b1;
                1: m_ready <= ($urandom_range(0, 1) == 1);
                2: m_ready <= ($urandom_range(0, 3) == 0);
                default: m_ready <= ($urandom_range(0, 7) != 0);
            endcase
        end
    end

    scaled_t want;

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (expected_results.size() == 0) begin
                note_error("result beat with nothing expected");
            end else begin
                want = expected_results.pop_front();
                check_field("u_current", m_u_current, want.u_cur);
                check_field("v_current", m_v_current, want.v_cur);
                check_field("w_current", m_w_current, want.w_cur);
                check_field("bus_volts", m_bus_volts, want.bus_v);
                check_field("bus_delta", m_bus_delta, want.delta);
                check_field("calib_done", m_calib_done, want.done);
            end
            results_seen <= results_seen + 1;
        end
    end

    // stimulus
    task automatic wait_idle();
        @(negedge aclk);
        while (pending_samples.size() != 0 || s_valid || expected_results.size() != 0)
            @(negedge aclk);
        @(posedge aclk);
    endtask

    task automatic write_config(factor_t cur_f, factor_t bus_f, logic dir);
        wait_idle();
        cfg_wr_en <= 1'b1;
        cfg_addr  <= REG_CURRENT_FACTOR;
        cfg_wdata <= cur_f;
        @(posedge aclk);
        cfg_addr  <= REG_BUS_FACTOR;
        cfg_wdata <= bus_f;
        @(posedge aclk);
        cfg_addr  <= REG_CURRENT_DIR;
        cfg_wdata <= {15'($urandom()), dir};
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        cur_factor_m = cur_f;
        bus_factor_m = bus_f;
        dir_m = dir;
    endtask

    task automatic push_sample(logic act, adc_code_t u, adc_code_t v, adc_code_t b);
        sample_t smp;
        smp.action = act;
        smp.u_code = u;
        smp.v_code = v;
        smp.bus_code = b;
        pending_samples.push_back(smp);
        if (act == ACT_CALIB)
            gen_cal_count = (gen_cal_count < AVG_COUNT) ? gen_cal_count + 1 : 0;
    endtask

    function automatic adc_code_t pick_code();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return '1;
            default: return adc_code_t'($urandom());
        endcase
    endfunction

    function automatic factor_t pick_factor();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return '1;
            default: return factor_t'($urandom());
        endcase
    endfunction

    function automatic adc_code_t near_code(int center, int spread);
        int x;
        x = center + int'($urandom_range(0, 2 * spread)) - spread;
        if (x < 0)
            x = 0;
        if (x > 4095)
            x = 4095;
        return adc_code_t'(x);
    endfunction

    // calibrate beats around the given centers until the averaging beat,
    // with convert beats mixed in
    task automatic run_calibration(int cu, int cv, int cb, int spread, int conv_pct);
        logic last;
        last = 1'b0;
        while (!last) begin
            if ($urandom_range(0, 99) < conv_pct) begin
                push_sample(ACT_CONVERT, pick_code(), pick_code(), pick_code());
            end else begin
                last = (gen_cal_count == AVG_COUNT);
                push_sample(ACT_CALIB, near_code(cu, spread), near_code(cv, spread),
                            near_code(cb, spread));
            end
        end
    endtask

    task automatic run_convert(int n, int noise_pct);
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 99) < noise_pct)
                push_sample(ACT_CALIB, pick_code(), pick_code(), pick_code());
            else
                push_sample(ACT_CONVERT, pick_code(), pick_code(), pick_code());
        end
    endtask

    initial begin
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // uncalibrated, registers at reset
        push_sample(ACT_CONVERT, 12'hfff, 12'hfff, 12'hfff);
        push_sample(ACT_CONVERT, 12'h000, 12'h000, 12'h000);

        write_config(16'hffff, 16'hffff, 1'b0);
        push_sample(ACT_CONVERT, 12'hfff, 12'h000, 12'hfff);
        push_sample(ACT_CONVERT, 12'h000, 12'hfff, 12'h000);
        push_sample(ACT_CONVERT, 12'hfff, 12'hfff, 12'hfff);
        push_sample(ACT_CONVERT, 12'h000, 12'h000, 12'h000);

        write_config(16'hffff, 16'hffff, 1'b1);
        push_sample(ACT_CONVERT, 12'hfff, 12'h000, 12'hfff);
        push_sample(ACT_CONVERT, 12'h000, 12'hfff, 12'h001);

        write_config(16'h0001, 16'h0001, 1'b0);
        push_sample(ACT_CONVERT, 12'h800, 12'h7ff, 12'h001);
        push_sample(ACT_CALIB, 12'hfff, 12'h000, 12'hfff);
        push_sample(ACT_CALIB, 12'hfff, 12'h000, 12'hfff);
        push_sample(ACT_CALIB, 12'h000, 12'hfff, 12'h000);
        push_sample(ACT_CONVERT, 12'h123, 12'hedc, 12'h555);

        // U and bus near full scale, V anywhere; converts meanwhile use old offsets
        write_config(pick_factor(), 16'hffff, 1'($urandom()));
        run_calibration(4095, $urandom_range(0, 4095), 4095, $urandom_range(0, 16), 8);

        write_config(16'hffff, 16'hffff, 1'b1);
        run_convert(120, 0);

        write_config(16'h0000, 16'h0000, 1'b0);
        run_convert(40, 0);

        // stray calibrate beats restart accumulation and clear the done flag
        write_config(pick_factor(), pick_factor(), 1'($urandom()));
        run_convert(100, 3);

        write_config(pick_factor(), pick_factor(), 1'($urandom()));
        run_convert(120, 2);

        wait_idle();
        repeat (20) @(posedge aclk);
        if (errors == 0)
            $display("adc_offset_calib_and_phase_scaling test passed");
        else
            $display("adc_offset_calib_and_phase_scaling test failed");
        $finish;
    end

endmodule

// File: sim.f
rtl/adcoc_pkg.sv
rtl/adc_offset_calib_and_phase_scaling.sv
bench/tb_top.sv
